@@ rtl/btsq_pkg.sv @@
// ============================================================================
// btsq_pkg: shared types and constants of the batch ticket shift queue
// Queue geometry, command and status codes, and the per-cell control bundle.
// ============================================================================
package btsq_pkg;

    localparam int DEPTH    = 16;
    localparam int MAX_EMIT = 16;
    localparam int TKT_W    = 16;
    localparam int CNT_W    = 8;
    localparam int FILL_W   = 5;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = ((OCC_W > CNT_W) ? OCC_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_DUMP = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_PUSH   = 3'd1,
        CELL_SHIFT  = 3'd2,
        CELL_ROTATE = 3'd3,
        CELL_CLEAR  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [OCC_W-1:0]  occ;
        logic [CNT_W-1:0]  count;
        logic [TKT_W-1:0]  counter;
    } cell_ctl_t;

endpackage

@@ rtl/btsq_cell.sv @@
// ============================================================================
// btsq_cell: one slot of the ticket queue
// Holds one ticket; loads a new ticket, takes its neighbor's value on a
// shift, or on a rotate (where the tail cell takes the head's value), or clears,
// as the shared control bundle says.
module btsq_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  btsq_pkg::cell_ctl_t         ctl,
    input  logic [btsq_pkg::IDX_W-1:0]  idx,
    input  logic [btsq_pkg::TKT_W-1:0]  next_data,
    input  logic [btsq_pkg::TKT_W-1:0]  head_data,
    output logic [btsq_pkg::TKT_W-1:0]  data
);

    logic [btsq_pkg::TKT_W-1:0] data_reg;
    logic [btsq_pkg::TKT_W-1:0] data_next;
    logic [btsq_pkg::SUM_W-1:0] idx_ext;
    logic [btsq_pkg::SUM_W-1:0] occ_ext;
    logic [btsq_pkg::SUM_W-1:0] end_ext;
    logic [btsq_pkg::SUM_W-1:0] tail_ext;
    logic [btsq_pkg::SUM_W-1:0] offset;

    assign idx_ext  = btsq_pkg::SUM_W'(idx);
    assign occ_ext  = btsq_pkg::SUM_W'(ctl.occ);
    assign end_ext  = occ_ext + btsq_pkg::SUM_W'(ctl.count);
    assign tail_ext = occ_ext - btsq_pkg::SUM_W'(1);
    assign offset   = idx_ext - occ_ext + btsq_pkg::SUM_W'(1);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            btsq_pkg::CELL_PUSH:
            begin
                if ((idx_ext >= occ_ext) && (idx_ext < end_ext))
                begin
                    data_next = ctl.counter + btsq_pkg::TKT_W'(offset);
                end
            end
            btsq_pkg::CELL_SHIFT:
            begin
                data_next = next_data;
            end
            btsq_pkg::CELL_ROTATE:
            begin
                if (idx_ext == tail_ext)
                begin
                    data_next = head_data;
                end
                else if (idx_ext < tail_ext)
                begin
                    data_next = next_data;
                end
            end
            btsq_pkg::CELL_CLEAR:
            begin
                data_next = '0;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

@@ rtl/batch_ticket_shift_queue_unit.sv @@
// Push, pop underflow, zero pops and unused commands: result registered in the cycle after the beat.
// A pop of n entries shifts the cell chain one place per cycle: result registered with the last shift.
// Dump: one result per stored entry, one per cycle while the output is ready; the beat first sets the dump state.
// Push takes one beat per cycle while the output is ready; pop and dump hold the input off until done.
// Reset: asynchronous, active low; queue empty, all slots zero, ticket counter zero.
// ============================================================================
// batch_ticket_shift_queue_unit: ticket queue in a chain of shift cells
// Pushes batches of numbered tickets, pops batches from the front by shifting
// (a pop of more than the fill clears the queue), and dumps the queue contents by rotating the occupied cells.
// ============================================================================
module batch_ticket_shift_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // command[1:0], count[9:2], zero[15:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // status[1:0], ticket[17:2], fill[22:18], zero[23]
    output logic        m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    state_t                             state_reg, state_next;
    logic [btsq_pkg::OCC_W-1:0]         occ_reg, occ_next;
    logic [btsq_pkg::TKT_W-1:0]         counter_reg, counter_next;
    logic [btsq_pkg::OCC_W-1:0]         step_reg, step_next;
    logic                               out_valid_reg, out_valid_next;
    btsq_pkg::status_t                  out_status_reg, out_status_next;
    logic [btsq_pkg::TKT_W-1:0]         out_ticket_reg, out_ticket_next;
    logic [btsq_pkg::FILL_W-1:0]        out_fill_reg, out_fill_next;
    logic                               out_last_reg, out_last_next;

    btsq_pkg::cell_ctl_t                ctl;
    logic [btsq_pkg::TKT_W-1:0]         slot [btsq_pkg::DEPTH];
    logic [btsq_pkg::TKT_W-1:0]         link [btsq_pkg::DEPTH];

    logic                               out_free;
    logic                               accept;
    btsq_pkg::cmd_t                     in_cmd;
    logic [btsq_pkg::CNT_W-1:0]         in_count;
    logic [btsq_pkg::SUM_W-1:0]         push_total;
    logic [btsq_pkg::SUM_W-1:0]         occ_ext;
    logic [btsq_pkg::SUM_W-1:0]         count_ext;

    assign in_cmd    = btsq_pkg::cmd_t'(s_axis_tdata[1:0]);
    assign in_count  = s_axis_tdata[9:2];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign occ_ext   = btsq_pkg::SUM_W'(occ_reg);
    assign count_ext = btsq_pkg::SUM_W'(in_count);
    assign push_total = occ_ext + count_ext;

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        counter_next    = counter_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_ticket_next = out_ticket_reg;
        out_fill_next   = out_fill_reg;
        out_last_next   = out_last_reg;
        ctl.op          = btsq_pkg::CELL_HOLD;
        ctl.occ         = occ_reg;
        ctl.count       = in_count;
        ctl.counter     = counter_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_ticket_next = '0;
                    out_last_next   = 1'b1;
                    out_status_next = btsq_pkg::STAT_OK;
                    case (in_cmd)
                        btsq_pkg::CMD_PUSH:
                        begin
                            ctl.op       = btsq_pkg::CELL_PUSH;
                            counter_next = counter_reg + btsq_pkg::TKT_W'(in_count);
                            if (push_total > btsq_pkg::SUM_W'(btsq_pkg::DEPTH))
                            begin
                                occ_next        = btsq_pkg::OCC_W'(btsq_pkg::DEPTH);
                                out_status_next = btsq_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                occ_next = btsq_pkg::OCC_W'(push_total);
                            end
                            out_fill_next  = btsq_pkg::FILL_W'(occ_next);
                            out_valid_next = 1'b1;
                        end
                        btsq_pkg::CMD_POP:
                        begin
                            if (count_ext > occ_ext)
                            begin
                                ctl.op          = btsq_pkg::CELL_CLEAR;
                                occ_next        = '0;
                                out_status_next = btsq_pkg::STAT_UNDERFLOW;
                                out_fill_next   = '0;
                                out_valid_next  = 1'b1;
                            end
                            else if (in_count == '0)
                            begin
                                out_fill_next  = btsq_pkg::FILL_W'(occ_reg);
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                occ_next   = btsq_pkg::OCC_W'(occ_ext - count_ext);
                                step_next  = btsq_pkg::OCC_W'(in_count);
                                state_next = ST_POP;
                            end
                        end
                        btsq_pkg::CMD_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_status_next = btsq_pkg::STAT_EMPTY;
                                out_fill_next   = '0;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                step_next  = '0;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            out_fill_next  = btsq_pkg::FILL_W'(occ_reg);
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    ctl.op    = btsq_pkg::CELL_SHIFT;
                    step_next = step_reg - btsq_pkg::OCC_W'(1);
                    if (step_reg == btsq_pkg::OCC_W'(1))
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = btsq_pkg::STAT_OK;
                        out_ticket_next = '0;
                        out_fill_next   = btsq_pkg::FILL_W'(occ_reg);
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    ctl.op    = btsq_pkg::CELL_ROTATE;
                    step_next = step_reg + btsq_pkg::OCC_W'(1);
                    if (int'(step_reg) < btsq_pkg::MAX_EMIT)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = btsq_pkg::STAT_OK;
                        out_ticket_next = slot[0];
                        out_fill_next   = btsq_pkg::FILL_W'(occ_reg);
                        out_last_next   = (step_reg == occ_reg - btsq_pkg::OCC_W'(1))
                                          || (int'(step_reg) == btsq_pkg::MAX_EMIT - 1);
                    end
                    if (step_reg == occ_reg - btsq_pkg::OCC_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            counter_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            counter_reg   <= counter_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_ticket_reg <= out_ticket_next;
        out_fill_reg   <= out_fill_next;
        out_last_reg   <= out_last_next;
    end

    for (genvar i = 0; i < btsq_pkg::DEPTH; i++)
    begin : g_cell
        if (i == btsq_pkg::DEPTH - 1)
        begin : g_tail
            assign link[i] = '0;
        end
        else
        begin : g_mid
            assign link[i] = slot[i+1];
        end

        btsq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .idx       (btsq_pkg::IDX_W'(i)),
            .next_data (link[i]),
            .head_data (slot[0]),
            .data      (slot[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_fill_reg, out_ticket_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= btsq_pkg::DEPTH)
        else $error("occupancy above depth");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    a_underflow_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_cmd == btsq_pkg::CMD_POP) && (count_ext > occ_ext))
        |=> (occ_reg == '0) && (slot[0] == '0))
        else $error("underflow did not clear queue");

    a_counter_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_cmd == btsq_pkg::CMD_PUSH))
        |=> counter_reg == $past(counter_reg) + btsq_pkg::TKT_W'($past(in_count)))
        else $error("ticket counter did not advance by count");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("beat accepted while busy");

endmodule

@@ tb/sv/btsq_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// btsq_checker: result checker for the batch ticket shift queue
// Watches both stream channels. Keeps its own copy of the queue contents,
// the fill and the ticket counter. Works out the result beats that each
// command beat should cause, and compares every output beat field by field
// with the oldest one still due.
// ============================================================================
module btsq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        btsq_pkg::status_t                  status;
        logic [btsq_pkg::TKT_W-1:0]         ticket;
        logic [btsq_pkg::FILL_W-1:0]        fill;
        logic                               last;
    } ticket_result_t;

    ticket_result_t                     due_results[$];
    ticket_result_t                     want;
    logic [btsq_pkg::TKT_W-1:0]         queue_slots[btsq_pkg::DEPTH];
    int                                 queue_fill;
    logic [btsq_pkg::TKT_W-1:0]         ticket_seq;

    logic [1:0]                         got_status;
    logic [btsq_pkg::TKT_W-1:0]         got_ticket;
    logic [btsq_pkg::FILL_W-1:0]        got_fill;

    assign got_status = m_axis_tdata[1:0];
    assign got_ticket = m_axis_tdata[17:2];
    assign got_fill   = m_axis_tdata[22:18];

    task automatic apply_command(input logic [1:0] cmd,
                                 input logic [btsq_pkg::CNT_W-1:0] cnt);
        btsq_pkg::status_t verdict;
        int      emit;
        verdict = btsq_pkg::STAT_OK;
        case (cmd)
            btsq_pkg::CMD_PUSH:
            begin
                for (int i = 0; i < cnt; i++)
                begin
                    ticket_seq = ticket_seq + 1'b1;
                    if (queue_fill < btsq_pkg::DEPTH)
                    begin
                        queue_slots[queue_fill] = ticket_seq;
                        queue_fill++;
                    end
                    else
                        verdict = btsq_pkg::STAT_OVERFLOW;
                end
            end
            btsq_pkg::CMD_POP:
            begin
                if (cnt > queue_fill)
                begin
                    for (int i = 0; i < btsq_pkg::DEPTH; i++)
                        queue_slots[i] = '0;
                    queue_fill = 0;
                    verdict = btsq_pkg::STAT_UNDERFLOW;
                end
                else
                begin
                    for (int i = 0; i + cnt < queue_fill; i++)
                        queue_slots[i] = queue_slots[i + cnt];
                    for (int i = queue_fill - cnt; i < queue_fill; i++)
                        queue_slots[i] = '0;
                    queue_fill = queue_fill - cnt;
                end
            end
            btsq_pkg::CMD_DUMP:
            begin
                if (queue_fill == 0)
                    due_results.push_back('{btsq_pkg::STAT_EMPTY, btsq_pkg::TKT_W'(0),
                                            btsq_pkg::FILL_W'(0), 1'b1});
                else
                begin
                    emit = (queue_fill > btsq_pkg::MAX_EMIT) ? btsq_pkg::MAX_EMIT
                                                             : queue_fill;
                    for (int i = 0; i < emit; i++)
                        due_results.push_back('{btsq_pkg::STAT_OK, queue_slots[i],
                                                btsq_pkg::FILL_W'(queue_fill),
                                                i == emit - 1});
                end
                return;
            end
            default: ;
        endcase
        due_results.push_back('{verdict, btsq_pkg::TKT_W'(0),
                                btsq_pkg::FILL_W'(queue_fill), 1'b1});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            for (int i = 0; i < btsq_pkg::DEPTH; i++)
                queue_slots[i] = '0;
            queue_fill = 0;
            ticket_seq = '0;
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected beat: status %0d ticket %0h fill %0d last %0b",
                                 $realtime, got_status, got_ticket, got_fill, m_axis_tlast);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got_status !== want.status || got_ticket !== want.ticket ||
                        got_fill !== want.fill || m_axis_tlast !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("%0t: mismatch (expected/actual): status %0d/%0d ",
                                   $realtime, want.status, got_status);
                            $display("ticket %0h/%0h fill %0d/%0d last %0b/%0b",
                                     want.ticket, got_ticket, want.fill, got_fill,
                                     want.last, m_axis_tlast);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tdata[1:0], s_axis_tdata[9:2]);
            pending = due_results.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench: stimulus and verdict for batch_ticket_shift_queue_unit
// Sends a directed run of push, pop, dump and unused commands, then random
// command beats in bursts, while the output side stalls on its own pattern
// and once holds off long enough to back the queue up. The checker beside
// the block predicts and compares every result beat.
// ============================================================================
module testbench;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 350;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          errors;
    int          pending;
    int          burst_left = 0;
    bit          hold_req   = 1'b0;

    batch_ticket_shift_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    btsq_checker queue_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_command(input logic [1:0] cmd,
                                input logic [btsq_pkg::CNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 16'($urandom);
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tdata  <= {6'd0, cnt, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Output side: stretches of steady, random and periodic ready, one long hold.
    initial
    begin
        int stretch;
        int mode;
        int period;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(1, 40);
            period  = $urandom_range(2, 5);
            for (int k = 0; k < stretch; k++)
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (k % period == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int         sent;
        int         pick;
        logic [1:0] cmd;
        logic [7:0] cnt;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(btsq_pkg::CMD_DUMP, 8'd0);
        send_command(btsq_pkg::CMD_POP, 8'd0);
        send_command(btsq_pkg::CMD_POP, 8'd1);
        send_command(btsq_pkg::CMD_PUSH, 8'd0);
        send_command(btsq_pkg::CMD_PUSH, 8'd1);
        send_command(btsq_pkg::CMD_DUMP, 8'd0);
        send_command(btsq_pkg::CMD_PUSH, 8'd255);
        send_command(btsq_pkg::CMD_DUMP, 8'd0);
        send_command(btsq_pkg::CMD_PUSH, 8'd1);
        send_command(btsq_pkg::CMD_POP, 8'd1);
        send_command(btsq_pkg::CMD_POP, 8'd3);
        send_command(CMD_UNUSED, 8'd0);
        send_command(CMD_UNUSED, 8'd255);
        send_command(btsq_pkg::CMD_POP, 8'd12);
        send_command(btsq_pkg::CMD_DUMP, 8'd0);
        send_command(btsq_pkg::CMD_PUSH, 8'd16);
        send_command(btsq_pkg::CMD_POP, 8'd17);
        send_command(btsq_pkg::CMD_PUSH, 8'd8);
        send_command(btsq_pkg::CMD_POP, 8'd255);
        send_command(btsq_pkg::CMD_PUSH, 8'd15);
        send_command(btsq_pkg::CMD_DUMP, 8'd0);
        send_command(btsq_pkg::CMD_POP, 8'd15);
        send_command(btsq_pkg::CMD_PUSH, 8'd170);
        send_command(btsq_pkg::CMD_POP, 8'd85);
        send_command(btsq_pkg::CMD_DUMP, 8'd0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 60)
                hold_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                cmd = 2'($urandom_range(0, 3));
                cnt = 8'($urandom);
            end
            else if (pick < 45)
            begin
                cmd = btsq_pkg::CMD_PUSH;
                cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
            end
            else if (pick < 75)
            begin
                cmd = btsq_pkg::CMD_POP;
                cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
            end
            else
            begin
                cmd = btsq_pkg::CMD_DUMP;
                cnt = 8'($urandom);
            end
            send_command(cmd, cnt);
            if (cmd != CMD_UNUSED)
                sent++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
